@@ rtl/core/brb_pkg.sv @@
// ----------------------------------------------------------------------------
// brb_pkg: shared types and constants of the byte ring buffer
// Command codes, transaction payload structs and configuration constants.
// ----------------------------------------------------------------------------
package brb_pkg;

  // default number of ring entries
  localparam int unsigned RING_DEPTH_DEFAULT = 1024;

  // field widths fixed by the transaction format
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned START_W = 10;

  // configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // register index, taken from paddr bit 2 (word aligned)
  localparam logic REG_IDX_CAPACITY = 1'b0;

  // capacity register value after reset
  localparam logic [COUNT_W-1:0] CAPACITY_RESET = 11'd1024;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH     = 3'd0,
    CMD_PULL     = 3'd1,
    CMD_SKIP     = 3'd2,
    CMD_PEEK_RUN = 3'd3,
    CMD_PEEK_MAX = 3'd4,
    CMD_CHECK    = 3'd5
  } brb_cmd_e;

  // input transaction
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [BYTE_W-1:0]  data_byte;
    logic [COUNT_W-1:0] count;
  } brb_in_t;

  // result transaction
  typedef struct packed {
    logic [BYTE_W-1:0]  read_byte;
    logic [START_W-1:0] seg1_start;
    logic [COUNT_W-1:0] seg1_length;
    logic [COUNT_W-1:0] seg2_length;
    logic [COUNT_W-1:0] fill_level;
    logic               overflow;
    logic               underflow;
  } brb_out_t;

endpackage

@@ rtl/core/brb_ring_mem.sv @@
// ----------------------------------------------------------------------------
// brb_ring_mem: ring byte store
// Single write port, single read port with registered read data; the read
// data register only loads on a read strobe, so it holds while unread.
// ----------------------------------------------------------------------------
module brb_ring_mem #(
  parameter int unsigned Depth = brb_pkg::RING_DEPTH_DEFAULT,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [AddrW-1:0]          wr_addr_i,
  input  logic [brb_pkg::BYTE_W-1:0] wr_data_i,
  input  logic                      rd_en_i,
  input  logic [AddrW-1:0]          rd_addr_i,
  output logic [brb_pkg::BYTE_W-1:0] rd_data_o
);

  logic [brb_pkg::BYTE_W-1:0] mem_q [Depth];
  logic [brb_pkg::BYTE_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/core/byte_ring_buffer_unit.sv @@
// ----------------------------------------------------------------------------
// byte_ring_buffer_unit: circular byte FIFO with segment peeks
// Ring store with read/write indices and fill count, APB capacity register.
// ----------------------------------------------------------------------------
// Each command transaction gives exactly one result transaction. A command
// is accepted in any cycle in which the result register is free or being
// emptied, so the unit sustains one command per clock; the result appears
// in the cycle after acceptance. The indices and fill count sit in flops and
// are updated at acceptance; the byte store is a one-write, one-read memory
// whose single registered read port serves the pull command; its read data
// register loads together with the result register. A push writes its byte
// through the write port in the accepting cycle, so a following pull of the
// same entry sees it. Writing the capacity register (byte address 0) empties
// the FIFO; the store itself is never cleared and needs no clearing pass.
// Capacity values of zero act as one, values above the ring depth as the
// depth. Configure only while no result is outstanding.
module byte_ring_buffer_unit #(
  parameter int unsigned RingDepth = brb_pkg::RING_DEPTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  brb_pkg::brb_in_t              in_data_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output brb_pkg::brb_out_t             out_data_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [brb_pkg::PADDR_W-1:0]   paddr,
  input  logic [brb_pkg::PDATA_W-1:0]   pwdata,
  output logic [brb_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned IdxW = $clog2(RingDepth);
  localparam int unsigned CapW = $clog2(RingDepth + 1);
  localparam int unsigned W    = (CapW > brb_pkg::COUNT_W) ? CapW : brb_pkg::COUNT_W;
  localparam int unsigned SumW = W + 1;
  localparam int unsigned CapResetInt =
    (1024 > RingDepth) ? RingDepth : 1024;
  localparam logic [CapW-1:0] CapReset = CapW'(CapResetInt);

  // ---------------------------------------------------------------------------
  // state
  logic [brb_pkg::COUNT_W-1:0] cap_raw_q;
  logic [CapW-1:0]             cap_eff_q, cap_eff_d;
  logic [IdxW-1:0]             rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]             wr_idx_q, wr_idx_d;
  logic [CapW-1:0]             fill_q, fill_d;

  logic                        out_valid_q;
  brb_pkg::brb_out_t           out_q, out_d;
  logic                        pull_ok_q, pull_ok_d;

  logic                        accept;
  logic                        cfg_write;
  logic                        push_en;
  logic [brb_pkg::BYTE_W-1:0]  mem_rdata;

  // working values
  logic [W-1:0]    cap_w, rd_w, wr_w, fill_w, cnt_w, m_w, len1_w, len2_w;
  logic [W-1:0]    rd_inc_w, wr_inc_w;
  logic [SumW-1:0] rd_skip_s, peek_s, check_s;
  logic            ovf, unf;
  brb_pkg::brb_cmd_e cmd;

  // ---------------------------------------------------------------------------
  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready
                     & (paddr[2] == brb_pkg::REG_IDX_CAPACITY);

  always_comb begin
    if (paddr[2] == brb_pkg::REG_IDX_CAPACITY) begin
      prdata = brb_pkg::PDATA_W'(cap_raw_q);
    end else begin
      prdata = '0;
    end
  end

  // saturate the written capacity to 1..depth
  always_comb begin
    if (pwdata[brb_pkg::COUNT_W-1:0] == '0) begin
      cap_eff_d = CapW'(1);
    end else if (W'(pwdata[brb_pkg::COUNT_W-1:0]) > W'(RingDepth)) begin
      cap_eff_d = CapW'(RingDepth);
    end else begin
      cap_eff_d = CapW'(pwdata[brb_pkg::COUNT_W-1:0]);
    end
  end

  // ---------------------------------------------------------------------------
  // handshake
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;
  assign cmd        = brb_pkg::brb_cmd_e'(in_data_i.cmd);

  // ---------------------------------------------------------------------------
  // command evaluation
  assign cap_w  = W'(cap_eff_q);
  assign rd_w   = W'(rd_idx_q);
  assign wr_w   = W'(wr_idx_q);
  assign fill_w = W'(fill_q);
  assign cnt_w  = W'(in_data_i.count);

  assign rd_inc_w  = rd_w + W'(1);
  assign wr_inc_w  = wr_w + W'(1);
  assign rd_skip_s = SumW'(rd_w) + SumW'(cnt_w);
  assign m_w       = (cnt_w > fill_w) ? fill_w : cnt_w;
  assign peek_s    = SumW'(rd_w) + SumW'(m_w);
  assign check_s   = SumW'(fill_w) + SumW'(cnt_w);

  always_comb begin
    rd_idx_d  = rd_idx_q;
    wr_idx_d  = wr_idx_q;
    fill_d    = fill_q;
    len1_w    = '0;
    len2_w    = '0;
    ovf       = 1'b0;
    unf       = 1'b0;
    pull_ok_d = 1'b0;
    push_en   = 1'b0;
    case (cmd)
      brb_pkg::CMD_PUSH: begin
        if (fill_w >= cap_w) begin
          ovf = 1'b1;
        end else begin
          push_en  = 1'b1;
          wr_idx_d = (wr_inc_w >= cap_w) ? '0 : IdxW'(wr_inc_w);
          fill_d   = fill_q + CapW'(1);
        end
      end
      brb_pkg::CMD_PULL: begin
        if (fill_w == '0) begin
          unf = 1'b1;
        end else begin
          pull_ok_d = 1'b1;
          rd_idx_d  = (rd_inc_w >= cap_w) ? '0 : IdxW'(rd_inc_w);
          fill_d    = fill_q - CapW'(1);
        end
      end
      brb_pkg::CMD_SKIP: begin
        if (cnt_w > fill_w) begin
          unf = 1'b1;
        end else begin
          if (rd_skip_s >= SumW'(cap_w)) begin
            rd_idx_d = IdxW'(rd_skip_s - SumW'(cap_w));
          end else begin
            rd_idx_d = IdxW'(rd_skip_s);
          end
          fill_d = CapW'(fill_w - cnt_w);
        end
      end
      brb_pkg::CMD_PEEK_RUN: begin
        if (fill_w == '0) begin
          len1_w = '0;
        end else if (wr_w <= rd_w) begin
          len1_w = cap_w - rd_w;
        end else begin
          len1_w = wr_w - rd_w;
        end
      end
      brb_pkg::CMD_PEEK_MAX: begin
        if (peek_s > SumW'(cap_w)) begin
          len1_w = cap_w - rd_w;
          len2_w = m_w - (cap_w - rd_w);
        end else begin
          len1_w = m_w;
        end
      end
      brb_pkg::CMD_CHECK: begin
        ovf = (check_s > SumW'(cap_w));
      end
      default: begin
      end
    endcase
  end

  // result fields other than the pulled byte
  always_comb begin
    out_d             = '0;
    out_d.seg1_start  = brb_pkg::START_W'(W'(rd_idx_d));
    out_d.seg1_length = brb_pkg::COUNT_W'(len1_w);
    out_d.seg2_length = brb_pkg::COUNT_W'(len2_w);
    out_d.fill_level  = brb_pkg::COUNT_W'(W'(fill_d));
    out_d.overflow    = ovf;
    out_d.underflow   = unf;
  end

  // ---------------------------------------------------------------------------
  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_raw_q   <= brb_pkg::CAPACITY_RESET;
      cap_eff_q   <= CapReset;
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_write) begin
        cap_raw_q <= pwdata[brb_pkg::COUNT_W-1:0];
        cap_eff_q <= cap_eff_d;
        rd_idx_q  <= '0;
        wr_idx_q  <= '0;
        fill_q    <= '0;
      end else if (accept) begin
        rd_idx_q <= rd_idx_d;
        wr_idx_q <= wr_idx_d;
        fill_q   <= fill_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q     <= out_d;
      pull_ok_q <= pull_ok_d;
    end
  end

  // ---------------------------------------------------------------------------
  // byte store
  brb_ring_mem #(
    .Depth (RingDepth),
    .AddrW (IdxW)
  ) u_ring_mem (
    .clk_i     (clk_i),
    .wr_en_i   (accept & push_en),
    .wr_addr_i (wr_idx_q),
    .wr_data_i (in_data_i.data_byte),
    .rd_en_i   (accept & pull_ok_d),
    .rd_addr_i (rd_idx_q),
    .rd_data_o (mem_rdata)
  );

  // result output, pulled byte joins from the store read register
  always_comb begin
    out_data_o           = out_q;
    out_data_o.read_byte = pull_ok_q ? mem_rdata : '0;
  end
  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------------
  // checks
  logic [SumW-1:0] ring_s;
  logic [W-1:0]    wr_expect_w;

  assign ring_s      = SumW'(rd_w) + SumW'(fill_w);
  assign wr_expect_w = (ring_s >= SumW'(cap_w)) ? W'(ring_s - SumW'(cap_w)) : W'(ring_s);

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cap_eff_q)
    else $error("fill count exceeds capacity");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (W'(rd_idx_q) < cap_w) && (W'(wr_idx_q) < cap_w))
    else $error("ring index beyond capacity");

  a_ring_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_w == wr_expect_w)
    else $error("write index does not match read index plus fill");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted transaction produced no result");

  a_cap_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_write |=> (cap_eff_q != '0) && (fill_q == '0))
    else $error("capacity write left bad state");

endmodule
